### hdl/tep_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tep_pkg
// Shared types, constants and lookup tables of the tone equalizer pixel unit.
// ----------------------------------------------------------------------------
package tep_pkg;

    localparam int PIX_W     = 24;
    localparam int L_W       = 25;
    localparam int EV_W      = 16;
    localparam int ACC_W     = 38;
    localparam int GAIN_W    = 17;
    localparam int GAIN_REGS = 8;
    localparam int GADDR_W   = 3;
    localparam int CORR_W    = 28;

    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd16384;
    localparam logic signed [EV_W-1:0] EV_FLOOR = -16'sd18432;
    localparam logic [14:0] LOG2E_Q14    = 15'd23637;
    localparam logic [15:0] INV_WSUM_Q16 = 16'd36971;
    localparam logic [25:0] DIV3_MUL     = 26'd44739243;

    // lightness methods
    localparam int LM_MEAN     = 0;
    localparam int LM_MIDRANGE = 1;
    localparam int LM_MAX      = 2;
    localparam int LM_NORM     = 3;

    localparam int LIGHT_METHOD_DEF = LM_MEAN;
    localparam int BAND_COUNT_DEF   = 16;

    // log2(1+k/16) in Q.16
    localparam logic [16:0] LOG_TAB [17] = '{
        17'd0, 17'd5732, 17'd11136, 17'd16248, 17'd21098, 17'd25711, 17'd30109,
        17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472, 17'd52911,
        17'd56229, 17'd59434, 17'd62534, 17'd65536};

    // 2^(-k/16) in Q.16
    localparam logic [16:0] EXP_TAB [17] = '{
        17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
        17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
        17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768};

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic           valid;
        logic [L_W-1:0] l;
        pixel_t         pix;
    } light_t;

    typedef struct packed {
        logic                   valid;
        logic signed [EV_W-1:0] ev;
        logic [ACC_W-1:0]       acc;
        pixel_t                 pix;
    } flow_t;

    // gain register that drives each band
    function automatic int band_reg(input int band);
        if (band <= 4)
            return 0;
        else if (band >= 11)
            return 7;
        else
            return band - 4;
    endfunction

endpackage
`default_nettype wire

### hdl/tep_light.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tep_light
// Pipelined lightness estimate of one pixel by the chosen method.
// ----------------------------------------------------------------------------
module tep_light #(
    parameter int LIGHT_METHOD = tep_pkg::LIGHT_METHOD_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire tep_pkg::pixel_t in_pix,
    output tep_pkg::light_t      out
);

    generate
        if (LIGHT_METHOD == tep_pkg::LM_MIDRANGE || LIGHT_METHOD == tep_pkg::LM_MAX) begin : g_minmax
            logic [23:0] mx, mn, mx_rg, mn_rg;
            tep_pkg::light_t out_reg;

            // extremes of the three channels
            always_comb
            begin
                mx_rg = (in_pix.red > in_pix.green) ? in_pix.red : in_pix.green;
                mn_rg = (in_pix.red < in_pix.green) ? in_pix.red : in_pix.green;
                mx    = (mx_rg > in_pix.blue) ? mx_rg : in_pix.blue;
                mn    = (mn_rg < in_pix.blue) ? mn_rg : in_pix.blue;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    out_reg <= '0;
                end
                else if (en)
                begin
                    out_reg.valid <= in_valid;
                    out_reg.pix   <= in_pix;
                    if (LIGHT_METHOD == tep_pkg::LM_MAX)
                        out_reg.l <= {1'b0, mx};
                    else
                        out_reg.l <= 25'(({1'b0, mn} + {1'b0, mx}) >> 1);
                end
            end

            assign out = out_reg;
        end
        else if (LIGHT_METHOD == tep_pkg::LM_NORM) begin : g_norm
            localparam int SQ_STEPS = 25;
            logic [47:0] sq_r_reg, sq_g_reg, sq_b_reg;
            logic [50:0] sum_reg;
            logic        vld0_reg, vld1_reg;
            tep_pkg::pixel_t pix0_reg, pix1_reg;
            logic [50:0] v_reg [SQ_STEPS];
            logic [50:0] r_reg [SQ_STEPS];
            logic        vld_reg [SQ_STEPS];
            tep_pkg::pixel_t pix_reg [SQ_STEPS];

            // squares, then their sum
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sq_r_reg <= '0;
                    sq_g_reg <= '0;
                    sq_b_reg <= '0;
                    sum_reg  <= '0;
                    vld0_reg <= 1'b0;
                    vld1_reg <= 1'b0;
                    pix0_reg <= '0;
                    pix1_reg <= '0;
                end
                else if (en)
                begin
                    sq_r_reg <= in_pix.red * in_pix.red;
                    sq_g_reg <= in_pix.green * in_pix.green;
                    sq_b_reg <= in_pix.blue * in_pix.blue;
                    vld0_reg <= in_valid;
                    pix0_reg <= in_pix;
                    sum_reg  <= 51'(sq_r_reg) + 51'(sq_g_reg) + 51'(sq_b_reg);
                    vld1_reg <= vld0_reg;
                    pix1_reg <= pix0_reg;
                end
            end

            // one result bit per stage of the square root
            for (genvar i = 0; i < SQ_STEPS; i++) begin : g_step
                localparam logic [50:0] BIT = 51'd1 << (48 - 2 * i);
                logic [50:0] v_in, r_in, t;
                logic        vld_in;
                tep_pkg::pixel_t pix_in;

                if (i == 0) begin : g_first
                    assign v_in   = sum_reg;
                    assign r_in   = '0;
                    assign vld_in = vld1_reg;
                    assign pix_in = pix1_reg;
                end
                else begin : g_next
                    assign v_in   = v_reg[i-1];
                    assign r_in   = r_reg[i-1];
                    assign vld_in = vld_reg[i-1];
                    assign pix_in = pix_reg[i-1];
                end

                assign t = r_in + BIT;

                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        v_reg[i]   <= '0;
                        r_reg[i]   <= '0;
                        vld_reg[i] <= 1'b0;
                        pix_reg[i] <= '0;
                    end
                    else if (en)
                    begin
                        vld_reg[i] <= vld_in;
                        pix_reg[i] <= pix_in;
                        if (v_in >= t)
                        begin
                            v_reg[i] <= v_in - t;
                            r_reg[i] <= (r_in >> 1) + BIT;
                        end
                        else
                        begin
                            v_reg[i] <= v_in;
                            r_reg[i] <= r_in >> 1;
                        end
                    end
                end
            end

            assign out.valid = vld_reg[SQ_STEPS-1];
            assign out.l     = r_reg[SQ_STEPS-1][24:0];
            assign out.pix   = pix_reg[SQ_STEPS-1];
        end
        else begin : g_mean
            logic [25:0] sum_reg;
            logic [51:0] prod;
            logic        vld0_reg;
            tep_pkg::pixel_t pix0_reg;
            tep_pkg::light_t out_reg;

            // divide by three through the reciprocal
            assign prod = sum_reg * tep_pkg::DIV3_MUL;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sum_reg  <= '0;
                    vld0_reg <= 1'b0;
                    pix0_reg <= '0;
                    out_reg  <= '0;
                end
                else if (en)
                begin
                    sum_reg       <= 26'(in_pix.red) + 26'(in_pix.green) + 26'(in_pix.blue);
                    vld0_reg      <= in_valid;
                    pix0_reg      <= in_pix;
                    out_reg.valid <= vld0_reg;
                    out_reg.pix   <= pix0_reg;
                    out_reg.l     <= prod[51:27];
                end
            end

            assign out = out_reg;
        end
    endgenerate

endmodule
`default_nettype wire

### hdl/tep_expo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tep_expo
// Exposure in Q5.10 EV from the lightness: leading one plus table log2.
// ----------------------------------------------------------------------------
module tep_expo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire tep_pkg::light_t in,
    output tep_pkg::flow_t       out
);

    logic [4:0]  p;
    logic [4:0]  p1_reg, p2_reg, p3_reg;
    logic [24:0] l1_reg;
    logic        z1_reg, z2_reg, z3_reg;
    logic        v1_reg, v2_reg, v3_reg;
    tep_pkg::pixel_t pix1_reg, pix2_reg, pix3_reg;
    logic [31:0] shifted;
    logic [3:0]  idx2_reg;
    logic [15:0] rem2_reg;
    logic [16:0] base_tab, next_tab;
    logic [12:0] diff;
    logic [28:0] prod;
    logic [16:0] base3_reg;
    logic [12:0] psh3_reg;
    logic [16:0] lf;
    logic signed [16:0] ev_raw;
    tep_pkg::flow_t out_reg;

    localparam logic signed [16:0] FLOOR17 = -17'sd18432;

    // position of the leading one
    always_comb
    begin
        p = '0;
        for (int i = 0; i < 25; i++)
        begin
            if (in.l[i])
                p = 5'(i);
        end
    end

    // left-align the bits below the leading one
    assign shifted = {7'b0, l1_reg} << (5'd31 - p1_reg);

    // table interpolation
    assign base_tab = tep_pkg::LOG_TAB[5'(idx2_reg)];
    assign next_tab = tep_pkg::LOG_TAB[5'(idx2_reg) + 5'd1];
    assign diff     = 13'(next_tab - base_tab);
    assign prod     = diff * rem2_reg;

    // integer part plus fraction, clamped at the floor
    assign lf     = base3_reg + 17'(psh3_reg);
    assign ev_raw = ((17'(p3_reg) - 17'sd20) <<< 10) + 17'(lf >> 6);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg    <= '0;
            l1_reg    <= '0;
            z1_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            pix1_reg  <= '0;
            p2_reg    <= '0;
            z2_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            pix2_reg  <= '0;
            idx2_reg  <= '0;
            rem2_reg  <= '0;
            p3_reg    <= '0;
            z3_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            pix3_reg  <= '0;
            base3_reg <= '0;
            psh3_reg  <= '0;
            out_reg   <= '0;
        end
        else if (en)
        begin
            p1_reg    <= p;
            l1_reg    <= in.l;
            z1_reg    <= (in.l == '0);
            v1_reg    <= in.valid;
            pix1_reg  <= in.pix;

            p2_reg    <= p1_reg;
            z2_reg    <= z1_reg;
            v2_reg    <= v1_reg;
            pix2_reg  <= pix1_reg;
            idx2_reg  <= shifted[30:27];
            rem2_reg  <= shifted[26:11];

            p3_reg    <= p2_reg;
            z3_reg    <= z2_reg;
            v3_reg    <= v2_reg;
            pix3_reg  <= pix2_reg;
            base3_reg <= base_tab;
            psh3_reg  <= prod[28:16];

            out_reg.valid <= v3_reg;
            out_reg.pix   <= pix3_reg;
            out_reg.acc   <= '0;
            if (z3_reg || ev_raw < FLOOR17)
                out_reg.ev <= tep_pkg::EV_FLOOR;
            else
                out_reg.ev <= ev_raw[15:0];
        end
    end

    assign out = out_reg;

endmodule
`default_nettype wire

### hdl/tep_band_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tep_band_cell
// One Gaussian band: weight from the exposure, times gain, added to the sum.
// ----------------------------------------------------------------------------
module tep_band_cell #(
    parameter int BAND = 0
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic [tep_pkg::GAIN_W-1:0] gain,
    input  wire tep_pkg::flow_t             in,
    output tep_pkg::flow_t                  out
);

    localparam int CENTER = (-22 + 2 * BAND) * 1024;

    tep_pkg::flow_t f1_reg, f2_reg, f3_reg, f4_reg, out_reg;
    logic signed [16:0] d;
    logic [14:0] ad;
    logic [29:0] d2_reg;
    logic [44:0] yprod;
    logic [28:0] y_reg;
    logic [16:0] base_tab, next_tab;
    logic [11:0] diff;
    logic [27:0] prod;
    logic [8:0]  n3_reg;
    logic [16:0] base3_reg;
    logic [11:0] psh3_reg;
    logic [16:0] w;
    logic [16:0] w4_reg;
    logic [33:0] wg;

    // distance to the band centre
    assign d  = {in.ev[15], in.ev} - 17'(CENTER);
    assign ad = d[16] ? 15'(-d) : d[14:0];

    // exponent in Q.20
    assign yprod = d2_reg * tep_pkg::LOG2E_Q14;

    // 2^-y by table
    assign base_tab = tep_pkg::EXP_TAB[5'(y_reg[19:16])];
    assign next_tab = tep_pkg::EXP_TAB[5'(y_reg[19:16]) + 5'd1];
    assign diff     = 12'(base_tab - next_tab);
    assign prod     = diff * y_reg[15:0];
    assign w        = base3_reg - 17'(psh3_reg);

    // weighted gain
    assign wg = w4_reg * gain;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_reg    <= '0;
            f2_reg    <= '0;
            f3_reg    <= '0;
            f4_reg    <= '0;
            out_reg   <= '0;
            d2_reg    <= '0;
            y_reg     <= '0;
            n3_reg    <= '0;
            base3_reg <= '0;
            psh3_reg  <= '0;
            w4_reg    <= '0;
        end
        else if (en)
        begin
            f1_reg    <= in;
            d2_reg    <= ad * ad;

            f2_reg    <= f1_reg;
            y_reg     <= yprod[44:16];

            f3_reg    <= f2_reg;
            n3_reg    <= y_reg[28:20];
            base3_reg <= base_tab;
            psh3_reg  <= prod[27:16];

            f4_reg    <= f3_reg;
            if (n3_reg > 9'd16)
                w4_reg <= '0;
            else
                w4_reg <= w >> n3_reg[4:0];

            out_reg.valid <= f4_reg.valid;
            out_reg.ev    <= f4_reg.ev;
            out_reg.pix   <= f4_reg.pix;
            out_reg.acc   <= f4_reg.acc + 38'(wg);
        end
    end

    assign out = out_reg;

endmodule
`default_nettype wire

### hdl/tone_equalizer_pixel_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tone_equalizer_pixel_unit
// Exposure-dependent gain over sixteen Gaussian bands, applied to RGB.
// ----------------------------------------------------------------------------
// path: lightness by the chosen method, exposure, one band cell per band,
//   then correction (the norm takes one square-root bit per stage)
// throughput: one pixel per cycle; the whole pipeline holds only while a
//   result sits in the output register and is not taken
// reset: clears all valid flags; every gain returns to 1.0
module tone_equalizer_pixel_unit #(
    parameter int LIGHT_METHOD = tep_pkg::LIGHT_METHOD_DEF,
    parameter int BAND_COUNT   = tep_pkg::BAND_COUNT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // red_in, green_in, blue_in
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // red_out, green_out, blue_out
    input  wire logic        cfg_we,
    input  wire logic [tep_pkg::GADDR_W-1:0] cfg_addr,
    input  wire logic [tep_pkg::GAIN_W-1:0]  cfg_wdata
);

    logic en;
    logic [tep_pkg::GAIN_W-1:0] gain_reg [tep_pkg::GAIN_REGS];
    tep_pkg::pixel_t in_pix;
    tep_pkg::light_t light;
    tep_pkg::flow_t  chain [BAND_COUNT+1];
    logic [53:0] cprod;
    logic [tep_pkg::CORR_W-1:0] corr_reg;
    logic        v1_reg, v2_reg, out_valid_reg;
    tep_pkg::pixel_t pix1_reg;
    logic [51:0] pr_reg, pg_reg, pb_reg;
    logic [32:0] rr, rg, rb;
    logic [71:0] out_data_reg;

    // pipeline advances unless the output beat is stuck
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    assign in_pix.red   = s_tdata[23:0];
    assign in_pix.green = s_tdata[47:24];
    assign in_pix.blue  = s_tdata[71:48];

    // gain registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tep_pkg::GAIN_REGS; i++)
                gain_reg[i] <= tep_pkg::GAIN_ONE;
        end
        else if (cfg_we)
        begin
            gain_reg[cfg_addr] <= cfg_wdata;
        end
    end

    // lightness and exposure front end
    tep_light #(
        .LIGHT_METHOD(LIGHT_METHOD)
    ) u_light (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .in_pix   (in_pix),
        .out      (light)
    );

    tep_expo u_expo (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .in    (light),
        .out   (chain[0])
    );

    // row of band cells accumulating the weighted gains
    generate
        for (genvar k = 0; k < BAND_COUNT; k++) begin : g_band
            tep_band_cell #(
                .BAND(k)
            ) u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (en),
                .gain  (gain_reg[tep_pkg::band_reg(k)]),
                .in    (chain[k]),
                .out   (chain[k+1])
            );
        end
    endgenerate

    // correction factor, channel products, rounding with saturation
    assign cprod = chain[BAND_COUNT].acc * tep_pkg::INV_WSUM_Q16 + 54'(1) * (54'd1 << 25);
    assign rr = 33'((pr_reg + 52'd524288) >> 20);
    assign rg = 33'((pg_reg + 52'd524288) >> 20);
    assign rb = 33'((pb_reg + 52'd524288) >> 20);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corr_reg      <= '0;
            v1_reg        <= 1'b0;
            pix1_reg      <= '0;
            pr_reg        <= '0;
            pg_reg        <= '0;
            pb_reg        <= '0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else if (en)
        begin
            corr_reg <= cprod[53:26];
            v1_reg   <= chain[BAND_COUNT].valid;
            pix1_reg <= chain[BAND_COUNT].pix;

            pr_reg   <= pix1_reg.red * corr_reg;
            pg_reg   <= pix1_reg.green * corr_reg;
            pb_reg   <= pix1_reg.blue * corr_reg;
            v2_reg   <= v1_reg;

            out_valid_reg       <= v2_reg;
            out_data_reg[23:0]  <= (rr > 33'hFFFFFF) ? 24'hFFFFFF : rr[23:0];
            out_data_reg[47:24] <= (rg > 33'hFFFFFF) ? 24'hFFFFFF : rg[23:0];
            out_data_reg[71:48] <= (rb > 33'hFFFFFF) ? 24'hFFFFFF : rb[23:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // input side stalls exactly when a beat waits at the output
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    // a stalled pipeline keeps its result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |=> $stable(m_tdata) && m_tvalid)
        else $error("result changed during stall");

    // exposure stays within its clamped range
    a_ev: assert property (@(posedge clk) disable iff (!rst_n)
        chain[0].valid |-> (chain[0].ev >= tep_pkg::EV_FLOOR) && (chain[0].ev <= 16'sd5120))
        else $error("exposure out of range");

endmodule
`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Pixel-level check of the tone equalizer: random and edge-case RGB beats are
// streamed through under several gain settings, with random gaps on both
// sides, and every output beat is compared with a bit-exact predictor.
// ----------------------------------------------------------------------------

class gain_scoreboard;
    logic [16:0] gain [8];
    logic [71:0] pending [$];
    int          errors;
    int          checked;

    function new();
        errors  = 0;
        checked = 0;
        for (int i = 0; i < 8; i++)
            gain[i] = 17'd16384;
    endfunction

    // lightness by channel mean (default method)
    function automatic logic [24:0] lightness(logic [23:0] r, logic [23:0] g, logic [23:0] b);
        logic [25:0] s;
        s = r + g + b;
        return s / 3;
    endfunction

    function automatic int exposure_q10(logic [24:0] l);
        int unsigned lt [17] = '{0, 5732, 11136, 16248, 21098, 25711, 30109, 34312,
            38336, 42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536};
        int          p;
        logic [63:0] frac;
        int unsigned idx;
        int unsigned rem;
        int unsigned lf;
        int          ev;
        if (l == 0)
            return -18 * 1024;
        p = 31;
        while (l[p] == 1'b0 || p > 24)
        begin
            if (p <= 24 && l[p])
                break;
            p--;
        end
        frac = ({39'd0, l} << (32 - p)) & 64'hFFFF_FFFF;
        idx  = frac[31:28];
        rem  = frac[27:12];
        lf   = lt[idx] + (((lt[idx + 1] - lt[idx]) * rem) >> 16);
        ev   = (p - 20) * 1024 + int'(lf >> 6);
        return (ev < -18 * 1024) ? -18 * 1024 : ev;
    endfunction

    function automatic longint unsigned band_weight(int ev, int band);
        longint unsigned et [17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535,
            48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
        int              d;
        longint unsigned ad;
        longint unsigned y;
        longint unsigned n;
        longint unsigned f;
        longint unsigned w;
        d  = ev - (-22 + 2 * band) * 1024;
        ad = (d < 0) ? -d : d;
        y  = (ad * ad * 23637) >> 16;
        n  = y >> 20;
        f  = y & 64'hFFFFF;
        if (n > 16)
            return 0;
        w = et[f >> 16] - (((et[f >> 16] - et[(f >> 16) + 1]) * (f & 64'hFFFF)) >> 16);
        return w >> n;
    endfunction

    function automatic int gain_index(int band);
        if (band <= 4)
            return 0;
        else if (band >= 11)
            return 7;
        return band - 4;
    endfunction

    // note an accepted input pixel and queue its corrected value
    function void note_pixel(logic [71:0] px);
        logic [23:0]     ch [3];
        longint unsigned acc;
        longint unsigned corr;
        longint unsigned v;
        int              ev;
        logic [71:0]     res;
        for (int c = 0; c < 3; c++)
            ch[c] = px[24*c +: 24];
        ev  = exposure_q10(lightness(ch[0], ch[1], ch[2]));
        acc = 0;
        for (int b = 0; b < 16; b++)
            acc += band_weight(ev, b) * gain[gain_index(b)];
        corr = (acc * 36971 + (64'd1 << 25)) >> 26;
        for (int c = 0; c < 3; c++)
        begin
            v = (ch[c] * corr + (64'd1 << 19)) >> 20;
            res[24*c +: 24] = (v > 64'hFFFFFF) ? 24'hFFFFFF : v[23:0];
        end
        pending.push_back(res);
    endfunction

    function void check_pixel(logic [71:0] got);
        logic [71:0] want;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected beat %h", $time, got);
            errors++;
            return;
        end
        want = pending.pop_front();
        checked++;
        for (int c = 0; c < 3; c++)
            if (want[24*c +: 24] !== got[24*c +: 24])
            begin
                $display("%0t: channel %0d expected %h got %h", $time, c,
                         want[24*c +: 24], got[24*c +: 24]);
                errors++;
            end
    endfunction
endclass

module tb_top;

    localparam int DRAIN = 150;
    localparam int WATCHDOG = 5000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        cfg_we;
    logic [tep_pkg::GADDR_W-1:0] cfg_addr;
    logic [tep_pkg::GAIN_W-1:0]  cfg_wdata;

    gain_scoreboard sb;
    int  send_gap_pct;
    int  recv_gap_pct;
    bit  hold_off;
    int  idle_cycles;
    int  sent;

    tone_equalizer_pixel_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // receiver side: random back-pressure
    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_gap_pct);
    end

    // output check and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_pixel(m_tdata);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WATCHDOG)
            begin
                $display("%0t: watchdog expired", $time);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // offer one beat; valid stays high into the next beat unless a gap follows
    task automatic send_pixel(logic [71:0] px);
        if ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < send_gap_pct)
                @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_pixel(px);
        sent++;
        @(negedge clk);
    endtask

    task automatic write_gain(int idx, logic [16:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx[tep_pkg::GADDR_W-1:0];
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.gain[idx] = val;
        @(negedge clk);
    endtask

    // wait for all results, then let the pipeline run empty
    task automatic drain();
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    function automatic logic [23:0] rand_channel();
        case ($urandom_range(4))
            0: return 24'($urandom) >> $urandom_range(23);
            1: return 24'($urandom_range(15));
            2: return 24'(24'hFFFFFF - $urandom_range(255));
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic random_pixels(int n);
        logic [23:0] r;
        for (int i = 0; i < n; i++)
        begin
            r = rand_channel();
            if ($urandom_range(3) == 0)
                send_pixel({r, r, r});
            else
                send_pixel({rand_channel(), rand_channel(), rand_channel()});
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic set_gains(int mode);
        for (int i = 0; i < 8; i++)
            case (mode)
                0: write_gain(i, 17'd4096);
                1: write_gain(i, 17'd65536);
                2: write_gain(i, (i % 2) ? 17'd4096 : 17'd65536);
                3: write_gain(i, 17'($urandom_range(65536, 4096)));
                default: write_gain(i, 17'($urandom));
            endcase
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        hold_off = 1'b0;
        idle_cycles = 0;
        sent = 0;
        send_gap_pct = 6;
        recv_gap_pct = 52;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extremes, zero lightness, single channels, even powers of two
        send_pixel(72'd0);
        send_pixel({72{1'b1}});
        send_pixel({24'd0, 24'd0, 24'hFFFFFF});
        send_pixel({24'd0, 24'hFFFFFF, 24'd0});
        send_pixel({24'hFFFFFF, 24'd0, 24'd0});
        send_pixel({24'd1, 24'd1, 24'd1});
        send_pixel({24'd3, 24'd0, 24'd0});
        for (int k = 0; k < 24; k += 2)
            send_pixel({3{24'd1 << k}});
        send_pixel({3{24'hAAAAAA}});
        send_pixel({3{24'h555555}});
        random_pixels(150);
        drain();

        // gain extremes, first low, then high
        set_gains(0);
        random_pixels(100);
        drain();
        set_gains(1);
        send_pixel({72{1'b1}});
        random_pixels(100);

        // long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(negedge clk);
                hold_off = 1'b0;
            end
            random_pixels(60);
        join
        drain();

        send_gap_pct = 52;
        recv_gap_pct = 6;
        set_gains(2);
        random_pixels(120);
        drain();
        set_gains(4);
        write_gain(3, 17'd0);
        random_pixels(120);
        drain();

        send_gap_pct = 0;
        recv_gap_pct = 0;
        set_gains(3);
        random_pixels(200);
        drain();

        $display("covered %0d pixels, %0d results checked, under six gain settings",
                 sent, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
